// ===== hdl/bpk_pkg.sv =====
// ----------------------------------------------------------------------------
// bpk_pkg: shared types and constants of the MSB-first bit packer
// Field widths, mode codes, controller states and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bpk_pkg;

    localparam int C_MAX_FIELD_BITS = 64;
    localparam int C_MODE_W         = 2;
    localparam int C_COUNT_W        = 7;
    localparam int C_VALUE_W        = 64;
    localparam int C_BYTE_W         = 8;

    // Bit position 7 means no byte is open.
    localparam logic [2:0] C_NO_BYTE_OPEN = 3'd7;

    typedef enum logic [C_MODE_W-1:0] {
        MODE_UNSIGNED = 2'd0,
        MODE_SIGNED   = 2'd1,
        MODE_REALIGN  = 2'd2
    } t_mode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic load;   // capture a new field from the input channel
        logic step;   // write one chunk of the field into the open byte
    } t_ctrl_cmd;

    typedef struct packed {
        logic load_empty;  // the offered item writes no bits
        logic byte_done;   // this step completes the open byte
        logic step_final;  // this step writes the last bits of the field
    } t_dp_status;

endpackage

// ===== hdl/bpk_in_if.sv =====
// ----------------------------------------------------------------------------
// bpk_in_if: field input channel
// Valid/ready channel carrying one field write request per transaction.
// ----------------------------------------------------------------------------
interface bpk_in_if;
    import bpk_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [C_MODE_W-1:0]  mode;
    logic [C_COUNT_W-1:0] count;
    logic signed [C_VALUE_W-1:0] value;
    logic                 fill_bit;

    modport source (output valid, mode, count, value, fill_bit, input ready);
    modport sink   (input valid, mode, count, value, fill_bit, output ready);
endinterface

// ===== hdl/bpk_out_if.sv =====
// ----------------------------------------------------------------------------
// bpk_out_if: packed byte output channel
// Valid/ready channel carrying one completed byte per transaction.
// ----------------------------------------------------------------------------
interface bpk_out_if;
    import bpk_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_BYTE_W-1:0] out_byte;
    logic                last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== hdl/bpk_datapath.sv =====
// ----------------------------------------------------------------------------
// bpk_datapath: field shifter and byte assembler
// Holds the left-aligned field, the open byte and the output byte register.
// ----------------------------------------------------------------------------
module bpk_datapath #(
    parameter int MAX_FIELD_BITS = bpk_pkg::C_MAX_FIELD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpk_pkg::t_ctrl_cmd               i_cmd,
    output bpk_pkg::t_dp_status              o_status,
    input  logic [bpk_pkg::C_MODE_W-1:0]     i_mode,
    input  logic [bpk_pkg::C_COUNT_W-1:0]    i_count,
    input  logic signed [bpk_pkg::C_VALUE_W-1:0] i_value,
    input  logic                             i_fill_bit,
    output logic [bpk_pkg::C_BYTE_W-1:0]     o_out_byte,
    output logic                             o_last
);
    import bpk_pkg::*;

    localparam int W  = MAX_FIELD_BITS;
    localparam int RW = $clog2(MAX_FIELD_BITS + 1);

    logic [W-1:0]  r_field, n_field;
    logic [RW-1:0] r_rem, n_rem;
    logic [7:0]    r_partial, n_partial;
    logic [2:0]    r_bitpos, n_bitpos;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [RW-1:0] cnt_sat, shamt, load_n;
    logic [W-1:0]  val_w, sel_w, shifted, load_field;
    logic          neg;

    logic [3:0]    avail, k;
    logic [2:0]    rsh;
    logic [7:0]    chunk, mask, placed, step_partial;
    logic [RW-1:0] rem_after;
    logic          byte_done;

    // Load: build the left-aligned bit string and its length.
    always_comb begin
        cnt_sat = (i_count > C_COUNT_W'(MAX_FIELD_BITS)) ? RW'(MAX_FIELD_BITS)
                                                         : RW'(i_count);
        shamt   = RW'(MAX_FIELD_BITS) - cnt_sat;
        neg     = i_value[C_VALUE_W-1];
        val_w   = i_value[W-1:0];
        sel_w   = neg ? (W'(0) - val_w) : val_w;
        shifted = '0;
        load_field = '0;
        load_n     = '0;
        case (t_mode'(i_mode))
            MODE_UNSIGNED: begin
                load_field = val_w << shamt;
                load_n     = cnt_sat;
            end
            MODE_SIGNED: begin
                shifted    = sel_w << shamt;
                load_field = {neg, shifted[W-2:0]};
                load_n     = (cnt_sat == '0) ? RW'(1) : cnt_sat;
            end
            MODE_REALIGN: begin
                load_field = {W{i_fill_bit}};
                load_n     = (r_bitpos == C_NO_BYTE_OPEN) ? '0
                                                          : RW'({1'b0, r_bitpos} + 4'd1);
            end
            default: begin
                load_field = '0;
                load_n     = '0;
            end
        endcase
    end

    // Step: move up to one byte's worth of bits into the open byte.
    always_comb begin
        avail     = {1'b0, r_bitpos} + 4'd1;
        k         = (r_rem < RW'(avail)) ? 4'(r_rem) : avail;
        rsh       = 3'd7 - r_bitpos;
        chunk     = r_field[W-1 -: 8];
        mask      = (8'hFF >> rsh) & ~(8'hFF >> ({1'b0, rsh} + k));
        placed    = (chunk >> rsh) & mask;
        step_partial = r_partial | placed;
        byte_done = (k == avail);
        rem_after = r_rem - RW'(k);
    end

    always_comb begin
        n_field   = r_field;
        n_rem     = r_rem;
        n_partial = r_partial;
        n_bitpos  = r_bitpos;
        if (i_cmd.load) begin
            n_field = load_field;
            n_rem   = load_n;
        end else if (i_cmd.step) begin
            n_field = r_field << k;
            n_rem   = rem_after;
            if (byte_done) begin
                n_partial = '0;
                n_bitpos  = C_NO_BYTE_OPEN;
            end else begin
                n_partial = step_partial;
                n_bitpos  = r_bitpos - k[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_partial <= '0;
            r_bitpos  <= C_NO_BYTE_OPEN;
        end else begin
            r_rem     <= n_rem;
            r_partial <= n_partial;
            r_bitpos  <= n_bitpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field <= n_field;
        if (i_cmd.step && byte_done) begin
            r_out_byte <= step_partial;
            r_out_last <= (rem_after < RW'(8));
        end
    end

    assign o_status.load_empty = (load_n == '0);
    assign o_status.byte_done  = byte_done;
    assign o_status.step_final = (RW'(k) == r_rem);
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ===== hdl/bpk_controller.sv =====
// ----------------------------------------------------------------------------
// bpk_controller: packer sequencer
// Accepts one field at a time, steps the datapath and owns output valid.
// ----------------------------------------------------------------------------
module bpk_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bpk_pkg::t_ctrl_cmd   o_cmd,
    input  bpk_pkg::t_dp_status  i_status
);
    import bpk_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        slot_free  = !r_out_valid || i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.load_empty) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // Hold while a completed byte would overwrite one not yet taken.
                if (slot_free || !i_status.byte_done) begin
                    o_cmd.step = 1'b1;
                    if (i_status.step_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.step && i_status.byte_done) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/msb_first_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit: MSB-first variable-width bit packer
// Packs unsigned, sign-magnitude and realign requests into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one request per transaction: mode (unsigned field,
//         sign-magnitude field, realign), count, value and fill_bit.
//   o_out carries one completed byte per transaction; last marks the final
//         byte completed by a request. A request may complete no byte.
//   Bytes fill from bit 7 down to bit 0; bits left in the open byte carry
//   over to the next request.
// Sequencing:
//   A request is taken in the idle state; each following cycle moves up to
//   one byte's worth of bits into the open byte, except that a step that
//   would complete a byte waits while the output is stalled. A new request
//   is not taken until the current one has written its last bits; a
//   request that writes nothing leaves the block idle. A byte appears on
//   o_out the cycle after its step.
// Reset and stalls:
//   Reset empties the open byte and drops any pending output transaction.
//   When the receiver stalls, the step that would complete the next byte
//   waits; steps that only add bits to the open byte still advance.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unit #(
    parameter int MAX_FIELD_BITS = bpk_pkg::C_MAX_FIELD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpk_in_if.sink    i_in,
    bpk_out_if.source o_out
);
    import bpk_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // Sequencer: input handshake, step pacing and output valid.
    bpk_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (ctrl_cmd),
        .i_status    (dp_status)
    );

    // Datapath: field alignment, byte assembly and output payload.
    bpk_datapath #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .o_status   (dp_status),
        .i_mode     (i_in.mode),
        .i_count    (i_in.count),
        .i_value    (i_in.value),
        .i_fill_bit (i_in.fill_bit),
        .o_out_byte (o_out.out_byte),
        .o_last     (o_out.last)
    );

endmodule
